// ----- rtl/rss_pkg.sv -----
// rss_pkg: item types, register indexes, reset values and the per-channel
// sharpen kernel for the rgb sharpen stencil. No dependencies.
package rss_pkg;

  localparam int COORD_W = 11;
  localparam int PIXEL_W = 24;
  localparam int MAX_WIDTH_DEFAULT = 1024;

  localparam logic [COORD_W-1:0] IMAGE_WIDTH_RESET  = 11'd640;
  localparam logic [COORD_W-1:0] IMAGE_HEIGHT_RESET = 11'd480;

  // configuration register indexes
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  // item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] sharp_red;
    logic [7:0] sharp_green;
    logic [7:0] sharp_blue;
    logic       frame_end;
  } out_item_t;

  // 5*centre - up - down - left - right per channel, clamped to 0..255
  function automatic logic [PIXEL_W-1:0] sharpen(
    input logic [PIXEL_W-1:0] ctr,
    input logic [PIXEL_W-1:0] up,
    input logic [PIXEL_W-1:0] dn,
    input logic [PIXEL_W-1:0] lf,
    input logic [PIXEL_W-1:0] rt
  );
    logic signed [11:0]  s;
    logic [PIXEL_W-1:0]  o;
    o = '0;
    for (int k = 0; k < 3; k++) begin
      s = $signed({2'b00, ctr[k*8 +: 8], 2'b00}) + $signed({4'b0000, ctr[k*8 +: 8]})
        - $signed({4'b0000, up[k*8 +: 8]}) - $signed({4'b0000, dn[k*8 +: 8]})
        - $signed({4'b0000, lf[k*8 +: 8]}) - $signed({4'b0000, rt[k*8 +: 8]});
      if (s < 0) begin
        o[k*8 +: 8] = 8'd0;
      end else if (s > 12'sd255) begin
        o[k*8 +: 8] = 8'd255;
      end else begin
        o[k*8 +: 8] = s[7:0];
      end
    end
    return o;
  endfunction

endpackage

// ----- rtl/rss_ram.sv -----
// rss_ram: generic single-clock RAM, one write port and one read port,
// registered read data. No dependencies.
module rss_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/rgb_sharpen_3x3_stencil.sv -----
// rgb_sharpen_3x3_stencil: top level of the 3x3 rgb sharpen filter.
// Uses rss_pkg (types, constants, sharpen kernel) and rss_ram (line stores).
//
//   channel  signals                         item
//   pix      pix_valid, pix_stall, pix       in_item_t: kind, red, green, blue
//   res      res_valid, res_stall, res       out_item_t: sharp rgb, frame_end
//   cfg      cfg_write, cfg_index, cfg_data  image_width / image_height
//
// One item per cycle while pix_stall is low: each pixel reads both line stores
// once at its column and writes them back in the second stage (one read and one
// write port per store). Results are computed from stage s1, then registered.
// Output register plus one skid entry: pix_stall rises only when both hold results.
// Synchronous reset clears counters and valid bits; line stores are not cleared.
// A configuration write restarts the stream positions and pending count.
module rgb_sharpen_3x3_stencil #(
  parameter int MAX_WIDTH = rss_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pix_valid,
  output logic                        pix_stall,
  input  rss_pkg::in_item_t           pix,
  output logic                        res_valid,
  input  logic                        res_stall,
  output rss_pkg::out_item_t          res,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [rss_pkg::COORD_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = rss_pkg::COORD_W;
  localparam int PW = rss_pkg::PIXEL_W;

  typedef struct packed {
    logic          kind;
    logic [PW-1:0] px;
    logic          wr_ok;
    logic [AW-1:0] addr;
    logic          emit;
    logic          interior;
    logic          frame_end;
  } stage_t;

  // configuration and positions
  logic [CW-1:0] image_width, image_height;
  logic [CW-1:0] w_eff, h_eff;
  logic [CW-1:0] in_column, in_row, out_column, out_row;
  logic [CW:0]   pending;

  // pipeline
  logic          accept, adv, pop, push;
  logic          is_flush, emit, col_ok, shape_ok, interior, last_px;
  stage_t        s1, s1_next;
  logic          s1_valid;
  logic          fwd;
  logic [PW-1:0] fwd_top, fwd_mid;
  logic [PW-1:0] ram_top, ram_mid, top, mid, sharp;
  logic [PW-1:0] win [3][3];  // [column: 0 oldest][row: 0 top]
  logic          ram_we, ram_re;
  logic [AW-1:0] rd_addr;
  rss_pkg::out_item_t new_res, skid;
  logic          skid_valid;

  assign w_eff = (image_width == '0) ? CW'(1) : image_width;
  assign h_eff = (image_height == '0) ? CW'(1) : image_height;

  assign pix_stall = res_valid && skid_valid;
  assign adv       = !pix_stall;
  assign accept    = pix_valid && !pix_stall;
  assign pop       = res_valid && !res_stall;

  // accept-side decisions, from the item kind, the frame size and the position counters
  always_comb begin
    is_flush = (pix.kind == rss_pkg::KIND_FLUSH);
    col_ok   = 32'(in_column) < MAX_WIDTH;
    shape_ok = (w_eff >= CW'(3)) && (h_eff >= CW'(3)) && (32'(w_eff) <= MAX_WIDTH);
    if (is_flush) begin
      emit = (in_column == '0) && (in_row == '0) && (pending != '0);
    end else begin
      emit = pending > {1'b0, w_eff};
    end
    interior = shape_ok && (out_row != '0) && ((out_row + CW'(1)) < h_eff) &&
               (out_column != '0) && ((out_column + CW'(1)) < w_eff);
    last_px  = ((out_row + CW'(1)) >= h_eff) && ((out_column + CW'(1)) >= w_eff);
    rd_addr  = AW'(in_column);
    ram_re   = accept && !is_flush && col_ok;

    s1_next.kind      = pix.kind;
    s1_next.px        = {pix.red, pix.green, pix.blue};
    s1_next.wr_ok     = col_ok;
    s1_next.addr      = rd_addr;
    s1_next.emit      = emit;
    s1_next.interior  = interior;
    s1_next.frame_end = last_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= rss_pkg::IMAGE_WIDTH_RESET;
      image_height <= rss_pkg::IMAGE_HEIGHT_RESET;
      in_column    <= '0;
      in_row       <= '0;
      out_column   <= '0;
      out_row      <= '0;
      pending      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        rss_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        rss_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      pending    <= '0;
    end else if (accept) begin
      if (!is_flush) begin
        if ((in_column + CW'(1)) >= w_eff) begin
          in_column <= '0;
          in_row    <= ((in_row + CW'(1)) >= h_eff) ? '0 : in_row + CW'(1);
        end else begin
          in_column <= in_column + CW'(1);
        end
        if (!emit) begin
          pending <= pending + (CW+1)'(1);
        end
      end else if (emit) begin
        pending <= pending - (CW+1)'(1);
      end
      if (emit) begin
        if ((out_column + CW'(1)) >= w_eff) begin
          out_column <= '0;
          out_row    <= ((out_row + CW'(1)) >= h_eff) ? '0 : out_row + CW'(1);
        end else begin
          out_column <= out_column + CW'(1);
        end
      end
    end
  end

  // line stores: older holds row n-2, newer row n-1 at each column
  rss_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH), .AW(AW)) u_older (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (s1.addr),
    .wr_data (mid),
    .rd_en   (ram_re),
    .rd_addr (rd_addr),
    .rd_data (ram_top)
  );

  rss_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH), .AW(AW)) u_newer (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (s1.addr),
    .wr_data (s1.px),
    .rd_en   (ram_re),
    .rd_addr (rd_addr),
    .rd_data (ram_mid)
  );

  // second stage: read data back, shift the window, write the stores
  always_comb begin
    top = !s1.wr_ok ? '0 : (fwd ? fwd_top : ram_top);
    mid = !s1.wr_ok ? '0 : (fwd ? fwd_mid : ram_mid);
    ram_we = adv && s1_valid && (s1.kind == rss_pkg::KIND_PIXEL) && s1.wr_ok;
    push   = adv && s1_valid && s1.emit;
    if (s1.kind == rss_pkg::KIND_FLUSH) begin
      sharp = rss_pkg::sharpen(win[1][1], win[1][0], win[1][2], win[0][1], win[2][1]);
    end else begin
      // taps of the window as it stands after this pixel's shift
      sharp = rss_pkg::sharpen(win[2][1], win[2][0], win[2][2], win[1][1], mid);
    end
    new_res.sharp_red   = s1.interior ? sharp[23:16] : 8'd0;
    new_res.sharp_green = s1.interior ? sharp[15:8]  : 8'd0;
    new_res.sharp_blue  = s1.interior ? sharp[7:0]   : 8'd0;
    new_res.frame_end   = s1.frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
    if (ram_re) begin
      // read and write of one entry in the same cycle: take the new data
      fwd     <= ram_we && (s1.addr == rd_addr);
      fwd_top <= mid;
      fwd_mid <= s1.px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win[c][r] <= '0;
        end
      end
    end else if (adv && s1_valid && (s1.kind == rss_pkg::KIND_PIXEL)) begin
      for (int c = 0; c < 2; c++) begin
        for (int r = 0; r < 3; r++) begin
          win[c][r] <= win[c+1][r];
        end
      end
      win[2][0] <= top;
      win[2][1] <= mid;
      win[2][2] <= s1.px;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (!res_valid || pop) begin
        res       <= new_res;
        res_valid <= 1'b1;
      end else begin
        skid       <= new_res;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid) begin
        res        <= skid;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= 1'b0;
      end
    end
  end

  a_skid_behind_res: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry held without an output item");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= ({1'b0, w_eff} + (CW+1)'(1)))
    else $error("pending count above row length plus one");

  a_fwd_taken: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re && (s1.addr == rd_addr)) |=> fwd)
    else $error("same-entry read and write not forwarded");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push |=> res_valid)
    else $error("result pushed but no output item");

endmodule

// ----- tb/sv/sharpen_checker.sv -----
// sharpen_checker: watches the pixel, result and register channels of the rgb
// sharpen stencil, predicts every result and compares it with what comes out.
// Depends on rss_pkg for the item types, register indexes and reset values.
module sharpen_checker #(
  parameter int MAX_WIDTH = rss_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pix_valid,
  input  logic                        pix_stall,
  input  rss_pkg::in_item_t           pix,
  input  logic                        res_valid,
  input  logic                        res_stall,
  input  rss_pkg::out_item_t          res,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [rss_pkg::COORD_W-1:0] cfg_data,
  output int                          owed,
  output int                          mismatches,
  output int                          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [rss_pkg::PIXEL_W-1:0] upper_line [MAX_WIDTH];  // two rows back
  logic [rss_pkg::PIXEL_W-1:0] lower_line [MAX_WIDTH];  // one row back
  logic [rss_pkg::PIXEL_W-1:0] taps [3][3];  // [column, 0 oldest][row, 0 top]
  logic [rss_pkg::COORD_W-1:0] width_reg;
  logic [rss_pkg::COORD_W-1:0] height_reg;
  int unsigned in_col, in_row, out_col, out_row, lag;
  rss_pkg::out_item_t sharp_due [$];
  int errors = 0;
  int seen = 0;

  function automatic int unsigned frame_w();
    return (width_reg == 0) ? 32'd1 : 32'(width_reg);
  endfunction

  function automatic int unsigned frame_h();
    return (height_reg == 0) ? 32'd1 : 32'(height_reg);
  endfunction

  function automatic void restart_stream();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    lag = 0;
  endfunction

  function automatic void clear_model();
    width_reg = rss_pkg::IMAGE_WIDTH_RESET;
    height_reg = rss_pkg::IMAGE_HEIGHT_RESET;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    for (int c = 0; c < 3; c++) begin
      for (int q = 0; q < 3; q++) begin
        taps[c][q] = '0;
      end
    end
    restart_stream();
  endfunction

  function automatic logic [7:0] lane_sharpen(input int sh);
    int s;
    s = 5 * int'(taps[1][1][sh +: 8]) - int'(taps[1][0][sh +: 8])
      - int'(taps[1][2][sh +: 8]) - int'(taps[0][1][sh +: 8])
      - int'(taps[2][1][sh +: 8]);
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    return 8'(s);
  endfunction

  // result for the current output position, then advance it
  function automatic rss_pkg::out_item_t emit_sharpened();
    int unsigned w, h;
    rss_pkg::out_item_t r;
    w = frame_w();
    h = frame_h();
    r = '0;
    if (w >= 3 && h >= 3 && w <= MAX_WIDTH && out_row >= 1 && out_row + 1 < h &&
        out_col >= 1 && out_col + 1 < w) begin
      r.sharp_red = lane_sharpen(16);
      r.sharp_green = lane_sharpen(8);
      r.sharp_blue = lane_sharpen(0);
    end
    r.frame_end = (out_row + 1 >= h && out_col + 1 >= w);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) out_row = 0;
    end
    lag--;
    return r;
  endfunction

  function automatic bit stencil_step(input rss_pkg::in_item_t it,
                                      output rss_pkg::out_item_t r);
    int unsigned w, h;
    logic [rss_pkg::PIXEL_W-1:0] px, top_px, mid_px;
    w = frame_w();
    h = frame_h();
    r = '0;
    if (it.kind == rss_pkg::KIND_FLUSH) begin
      // flush only drains at a frame boundary with something still owed
      if (in_col == 0 && in_row == 0 && lag > 0) begin
        r = emit_sharpened();
        return 1'b1;
      end
      return 1'b0;
    end
    px = {it.red, it.green, it.blue};
    top_px = '0;
    mid_px = '0;
    if (in_col < MAX_WIDTH) begin
      top_px = upper_line[in_col];
      mid_px = lower_line[in_col];
      upper_line[in_col] = mid_px;
      lower_line[in_col] = px;
    end
    for (int c = 0; c < 2; c++) begin
      for (int q = 0; q < 3; q++) begin
        taps[c][q] = taps[c+1][q];
      end
    end
    taps[2][0] = top_px;
    taps[2][1] = mid_px;
    taps[2][2] = px;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
      if (in_row >= h) in_row = 0;
    end
    lag++;
    if (lag > w + 1) begin
      r = emit_sharpened();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    rss_pkg::out_item_t want;
    if (rst) begin
      clear_model();
      sharp_due.delete();
    end else begin
      // a result leaving now always belongs to an earlier item
      if (res_valid && !res_stall) begin
        if (sharp_due.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected result %02h %02h %02h end=%0b", $time,
                     res.sharp_red, res.sharp_green, res.sharp_blue, res.frame_end);
          end
        end else begin
          want = sharp_due.pop_front();
          seen++;
          if (res.sharp_red !== want.sharp_red || res.sharp_green !== want.sharp_green ||
              res.sharp_blue !== want.sharp_blue || res.frame_end !== want.frame_end) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: result mismatch, expected %02h %02h %02h end=%0b,",
                       $time, want.sharp_red, want.sharp_green, want.sharp_blue,
                       want.frame_end);
              $display("    got %02h %02h %02h end=%0b", res.sharp_red,
                       res.sharp_green, res.sharp_blue, res.frame_end);
            end
          end
        end
      end
      if (cfg_write) begin
        if (cfg_index == rss_pkg::CFG_IMAGE_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
        restart_stream();
      end
      if (pix_valid && !pix_stall) begin
        if (stencil_step(pix, want)) sharp_due.push_back(want);
      end
    end
    owed <= sharp_due.size();
    mismatches <= errors;
    checked <= seen;
  end

endmodule

// ----- tb/sv/testbench.sv -----
// testbench: top of the rgb sharpen stencil test; drives pixel frames, flush
// ticks and frame size writes. Depends on rss_pkg, the block and sharpen_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 200_000;
  localparam int SETTLE = 8;
  localparam int CW = rss_pkg::COORD_W;

  typedef enum {TEX_NOISE, TEX_SMOOTH, TEX_HARSH} texture_t;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pix_valid = 1'b0;
  logic pix_stall;
  rss_pkg::in_item_t pix = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  rss_pkg::out_item_t res;
  logic cfg_write = 1'b0;
  logic cfg_index = rss_pkg::CFG_IMAGE_WIDTH;
  logic [CW-1:0] cfg_data = '0;
  int owed, mismatches, checked;

  int cycles = 0;
  int burst_left = 0;
  int cur_w = int'(rss_pkg::IMAGE_WIDTH_RESET);
  int cur_h = int'(rss_pkg::IMAGE_HEIGHT_RESET);
  int backlog = 0;  // results the block still owes for the current stream
  int useful = 0;
  int n_pix = 0;
  int n_flush = 0;
  int n_settings = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int mode_left = 0;
  int run_left = 0;

  rgb_sharpen_3x3_stencil dut (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sharpen_checker u_checker (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .owed(owed), .mismatches(mismatches), .checked(checked)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, owed);
      $display("** rgb_sharpen_3x3_stencil: FAILED **");
      $finish;
    end
  end

  // receiver back-pressure, switching between random stall patterns
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      mode_left <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE: res_stall <= 1'b0;
      STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (run_left == 0) begin
          res_stall <= ~res_stall;
          run_left <= $urandom_range(1, 12);
        end else begin
          run_left <= run_left - 1;
        end
      end
    endcase
  end

  task automatic offer(input rss_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        pix_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    pix <= it;
    pix_valid <= 1'b1;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    rss_pkg::in_item_t it;
    it.kind = rss_pkg::KIND_PIXEL;
    it.red = r;
    it.green = g;
    it.blue = b;
    offer(it);
    n_pix++;
    useful++;
    backlog++;
    if (backlog > cur_w + 1) backlog--;
  endtask

  // channel bits are random on a flush too; the block ignores them
  task automatic send_flush();
    rss_pkg::in_item_t it;
    it.kind = rss_pkg::KIND_FLUSH;
    it.red = 8'($urandom);
    it.green = 8'($urandom);
    it.blue = 8'($urandom);
    offer(it);
    n_flush++;
  endtask

  task automatic drain_frame();
    while (backlog > 0) begin
      send_flush();
      useful++;
      backlog--;
    end
    if ($urandom_range(0, 3) == 0) send_flush();
  endtask

  // block idle: nothing owed and the output pipe empty
  task automatic settle();
    pix_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_frame(input int w, input int h);
    bit height_first;
    height_first = $urandom_range(0, 1);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= height_first ? rss_pkg::CFG_IMAGE_HEIGHT : rss_pkg::CFG_IMAGE_WIDTH;
    cfg_data <= height_first ? CW'(h) : CW'(w);
    @(posedge clk);
    cfg_index <= height_first ? rss_pkg::CFG_IMAGE_WIDTH : rss_pkg::CFG_IMAGE_HEIGHT;
    cfg_data <= height_first ? CW'(w) : CW'(h);
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_w = (w == 0) ? 1 : w;
    cur_h = (h == 0) ? 1 : h;
    backlog = 0;
    n_settings++;
  endtask

  function automatic logic [7:0] shade(input texture_t tex, input logic [7:0] base);
    logic [7:0] v;
    v = 8'($urandom);
    case (tex)
      TEX_SMOOTH: v = {base[7:4], v[3:0]};  // small steps keep neighbouring values close
      TEX_HARSH: v = {8{v[0]}};
      default: ;
    endcase
    return v;
  endfunction

  task automatic stream_frame(input int count, input texture_t tex);
    logic [7:0] base_r, base_g, base_b;
    base_r = 8'($urandom);
    base_g = 8'($urandom);
    base_b = 8'($urandom);
    for (int i = 0; i < count; i++) begin
      // flush inside a frame must be ignored
      if (i > 0 && $urandom_range(0, 15) == 0) send_flush();
      send_pixel(shade(tex, base_r), shade(tex, base_g), shade(tex, base_b));
    end
  endtask

  function automatic int pick_size(input int hi);
    int v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 2);
      5: v = $urandom_range(hi, 2 * hi);
      default: v = $urandom_range(3, hi);
    endcase
    return v;
  endfunction

  initial begin
    int start, frames;
    bit broken;
    texture_t tex;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // a partial frame at the reset size, then a write restarts the stream
    for (int i = 0; i < 3; i++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    send_flush();
    set_frame(3, 3);
    // center pixel: red clamps high, green clamps low, blue lands at 200
    for (int i = 0; i < 9; i++) begin
      if (i == 5) send_flush();
      if (i == 4) send_pixel(8'd255, 8'd0, 8'd60);
      else if (i % 2 == 1) send_pixel(8'd0, 8'd255, 8'(5 * (i + 1)));
      else send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
    drain_frame();
    send_flush();

    // degenerate sizes: zero width, single row, two columns, zero height
    set_frame(0, 4);
    stream_frame(4, TEX_NOISE);
    drain_frame();
    set_frame(9, 1);
    stream_frame(9, TEX_HARSH);
    drain_frame();
    set_frame(2, 5);
    stream_frame(10, TEX_NOISE);
    drain_frame();
    set_frame(16, 0);
    stream_frame(16, TEX_SMOOTH);
    drain_frame();

    start = useful;
    while (useful - start < 360) begin
      set_frame(pick_size(10), pick_size(6));
      frames = $urandom_range(1, 3);
      broken = 1'b0;
      for (int f = 0; f < frames && !broken; f++) begin
        tex = texture_t'($urandom_range(0, 2));
        if ($urandom_range(0, 9) == 0) begin
          // abandon the frame partway; the next write restarts
          stream_frame($urandom_range(1, cur_w * cur_h), tex);
          broken = 1'b1;
        end else begin
          stream_frame(cur_w * cur_h, tex);
          if ($urandom_range(0, 3) != 0) drain_frame();
        end
      end
      if (!broken && $urandom_range(0, 1) == 1) drain_frame();
    end

    settle();
    $display("sent %0d pixels and %0d flush ticks across %0d frame sizes,",
             n_pix, n_flush, n_settings);
    $display("%0d results checked under mixed output stall patterns", checked);
    if (mismatches == 0 && owed == 0) begin
      $display("** rgb_sharpen_3x3_stencil: PASSED **");
    end else begin
      $display("** rgb_sharpen_3x3_stencil: FAILED **");
    end
    $finish;
  end

endmodule

// ----- rgb_sharpen_3x3_stencil.f -----
rtl/rss_pkg.sv
rtl/rss_ram.sv
rtl/rgb_sharpen_3x3_stencil.sv
tb/sv/sharpen_checker.sv
tb/sv/testbench.sv
